// File: design/dfwpm_pkg.sv
// shared types, constants and codes of the fixed-width dna pattern matcher
// used by every module of the block but dfwpm_ram; depends on nothing

package dfwpm_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int MAX_WIDTH  = 32;
  localparam int ALPHABET   = 4;
  localparam int CODE_W     = 2;
  localparam int SYM_W      = 8;
  localparam int ID_W       = 11;
  localparam int POS_W      = 32;
  localparam int PW_W       = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int NODE_AW    = $clog2(MAX_NODES);
  localparam int LINK_W     = $clog2(MAX_NODES + 1);
  localparam int DEPTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int HAW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HIST_SIZE  = 2 ** HAW;
  localparam int SP_W       = HAW + 1;
  localparam int INFO_W     = 1 + ID_W + DEPTH_W;

  localparam logic [LINK_W-1:0] NUL_LINK = LINK_W'(MAX_NODES);

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DUP       = 2'd1,
    STAT_BAD_PAT   = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_A    = 3'd0,
    CFG_BASE_C    = 3'd1,
    CFG_BASE_G    = 3'd2,
    CFG_BASE_T    = 3'd3,
    CFG_PAT_WIDTH = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD_LOOK,
    S_LOAD_TGT,
    S_LOAD_LINK,
    S_CALL,
    S_CALL_WAIT,
    S_RETURN,
    S_POP_WAIT,
    S_FIN,
    S_FIN_WAIT
  } eng_state_t;

  typedef struct packed {
    op_t               op;
    logic [SYM_W-1:0]  symbol;
    logic              first;
    logic [ID_W-1:0]   pattern_id;
  } item_t;

  typedef struct packed {
    logic              match;
    logic [ID_W-1:0]   found_id;
    logic [POS_W-1:0]  end_position;
    status_t           status;
  } result_t;

  // suspended lookup: walk set means a failure link is being built for node
  typedef struct packed {
    logic               walk;
    logic [NODE_AW-1:0] node;
    logic [CODE_W-1:0]  code;
    logic [HAW-1:0]     tail;
  } frame_t;

  typedef struct packed {
    logic               child_we;
    logic [CODE_W-1:0]  child_code;
    logic               fail_we;
    logic               info_we;
    logic               init;
    logic [NODE_AW-1:0] node;
    logic [LINK_W-1:0]  link;
    logic               leaf;
    logic [ID_W-1:0]    id;
    logic [DEPTH_W-1:0] depth;
  } store_wr_t;

  typedef struct packed {
    logic [ALPHABET-1:0][LINK_W-1:0] child;
    logic [LINK_W-1:0]               fail;
    logic                            leaf;
    logic [ID_W-1:0]                 id;
    logic [DEPTH_W-1:0]              depth;
  } store_rd_t;

endpackage

// File: design/dna_fixed_width_multi_pattern_matcher_top.sv
// top level of the fixed-width dna multi-pattern matcher: config registers,
// letter mapping; depends on dfwpm_pkg, dfwpm_engine and dfwpm_node_store
//
//  channel   signals                               beat taken when
//  item      start, busy, item                     start & !busy
//  result    done, result                          done (no back pressure)
//  config    cfg_valid, cfg_ready, cfg_index/data  cfg_valid & cfg_ready
//
// a load beat reads the current node, then the target node, and makes a new
// node or writes a link where needed; a scan beat of a non-base letter resets
// the walk, else it follows failure links and builds shortcuts on the way,
// bounded by a lookup stack of 32 frames
// every beat gives exactly one result
// reset is synchronous; node memories need no clearing pass after reset
// config writes are taken at any time; the user must keep the block idle then, it is not enforced

module dna_fixed_width_multi_pattern_matcher_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  dfwpm_pkg::item_t                  item,
  output logic                              done,
  output dfwpm_pkg::result_t                result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dfwpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfwpm_pkg::SYM_W-1:0]       cfg_data
);

  logic [dfwpm_pkg::SYM_W-1:0]   base_a;
  logic [dfwpm_pkg::SYM_W-1:0]   base_c;
  logic [dfwpm_pkg::SYM_W-1:0]   base_g;
  logic [dfwpm_pkg::SYM_W-1:0]   base_t;
  logic [dfwpm_pkg::PW_W-1:0]    pat_width;
  logic [dfwpm_pkg::CODE_W-1:0]  code;
  logic                          code_ok;
  logic [dfwpm_pkg::NODE_AW-1:0] rd_addr;
  dfwpm_pkg::store_wr_t          store_wr;
  dfwpm_pkg::store_rd_t          store_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_a    <= 8'd65;
      base_c    <= 8'd67;
      base_g    <= 8'd71;
      base_t    <= 8'd84;
      pat_width <= 6'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (dfwpm_pkg::cfg_reg_t'(cfg_index))
        dfwpm_pkg::CFG_BASE_A:    base_a    <= cfg_data;
        dfwpm_pkg::CFG_BASE_C:    base_c    <= cfg_data;
        dfwpm_pkg::CFG_BASE_G:    base_g    <= cfg_data;
        dfwpm_pkg::CFG_BASE_T:    base_t    <= cfg_data;
        dfwpm_pkg::CFG_PAT_WIDTH: pat_width <= cfg_data[dfwpm_pkg::PW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // lowest code wins when several bases share a byte
  always_comb begin
    code    = '0;
    code_ok = 1'b1;
    priority if (item.symbol == base_a) begin
      code = 2'd0;
    end else if (item.symbol == base_c) begin
      code = 2'd1;
    end else if (item.symbol == base_g) begin
      code = 2'd2;
    end else if (item.symbol == base_t) begin
      code = 2'd3;
    end else begin
      code_ok = 1'b0;
    end
  end

  dfwpm_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .start_beat    (start && !busy),
    .item          (item),
    .code          (code),
    .code_ok       (code_ok),
    .pattern_width (pat_width),
    .busy          (busy),
    .done          (done),
    .result        (result),
    .rd_addr       (rd_addr),
    .wr            (store_wr),
    .rd            (store_rd)
  );

  dfwpm_node_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (store_wr),
    .rd      (store_rd)
  );

endmodule

// File: design/dfwpm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module dfwpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/dfwpm_node_store.sv
// trie node store: child links, failure links, leaf info; root child links in flops
// depends on dfwpm_pkg and dfwpm_ram

module dfwpm_node_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dfwpm_pkg::NODE_AW-1:0] rd_addr,
  input  dfwpm_pkg::store_wr_t          wr,
  output dfwpm_pkg::store_rd_t          rd
);

  localparam int NODE_AW = dfwpm_pkg::NODE_AW;
  localparam int LINK_W  = dfwpm_pkg::LINK_W;
  localparam int INFO_W  = dfwpm_pkg::INFO_W;
  localparam int ALPH    = dfwpm_pkg::ALPHABET;

  logic [LINK_W-1:0] root_child [ALPH];
  logic [LINK_W-1:0] child_q [ALPH];
  logic [ALPH-1:0]   child_we;
  logic [LINK_W-1:0] child_wd;
  logic              fail_we;
  logic [LINK_W-1:0] fail_wd;
  logic [LINK_W-1:0] fail_q;
  logic              info_we;
  logic [INFO_W-1:0] info_wd;
  logic [INFO_W-1:0] info_q;
  logic              rd_root;
  logic              wr_root;

  assign wr_root  = (wr.node == '0);
  assign child_wd = wr.init ? dfwpm_pkg::NUL_LINK : wr.link;
  assign fail_we  = wr.init | wr.fail_we;
  assign fail_wd  = wr.init ? dfwpm_pkg::NUL_LINK : wr.link;
  assign info_we  = wr.init | wr.info_we;
  assign info_wd  = {wr.leaf, wr.id, wr.depth};

  for (genvar k = 0; k < ALPH; k++) begin : g_child
    assign child_we[k] = wr.init |
      (wr.child_we && !wr_root && (wr.child_code == dfwpm_pkg::CODE_W'(k)));

    dfwpm_ram #(.WIDTH(LINK_W), .DEPTH(dfwpm_pkg::MAX_NODES)) u_child_ram (
      .clk   (clk),
      .we    (child_we[k]),
      .waddr (wr.node),
      .wdata (child_wd),
      .raddr (rd_addr),
      .rdata (child_q[k])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        root_child[k] <= dfwpm_pkg::NUL_LINK;
      end else if (wr.child_we && wr_root &&
                   (wr.child_code == dfwpm_pkg::CODE_W'(k))) begin
        root_child[k] <= wr.link;
      end
    end

    assign rd.child[k] = rd_root ? root_child[k] : child_q[k];
  end

  dfwpm_ram #(.WIDTH(LINK_W), .DEPTH(dfwpm_pkg::MAX_NODES)) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (wr.node),
    .wdata (fail_wd),
    .raddr (rd_addr),
    .rdata (fail_q)
  );

  dfwpm_ram #(.WIDTH(INFO_W), .DEPTH(dfwpm_pkg::MAX_NODES)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (wr.node),
    .wdata (info_wd),
    .raddr (rd_addr),
    .rdata (info_q)
  );

  always_ff @(posedge clk) begin
    rd_root <= (rd_addr == '0);
  end

  // root has depth zero and is never a leaf
  assign rd.fail = fail_q;
  assign {rd.leaf, rd.id, rd.depth} = rd_root ? '0 : info_q;

endmodule

// File: design/dfwpm_engine.sv
// sequencer for pattern loads and subject scans over the shared node store,
// with lookup stack and symbol history; depends on dfwpm_pkg and dfwpm_ram

module dfwpm_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start_beat,
  input  dfwpm_pkg::item_t                item,
  input  logic [dfwpm_pkg::CODE_W-1:0]    code,
  input  logic                            code_ok,
  input  logic [dfwpm_pkg::PW_W-1:0]      pattern_width,
  output logic                            busy,
  output logic                            done,
  output dfwpm_pkg::result_t              result,
  output logic [dfwpm_pkg::NODE_AW-1:0]   rd_addr,
  output dfwpm_pkg::store_wr_t            wr,
  input  dfwpm_pkg::store_rd_t            rd
);

  localparam int NODE_AW = dfwpm_pkg::NODE_AW;
  localparam int LINK_W  = dfwpm_pkg::LINK_W;
  localparam int DEPTH_W = dfwpm_pkg::DEPTH_W;
  localparam int CODE_W  = dfwpm_pkg::CODE_W;
  localparam int HAW     = dfwpm_pkg::HAW;
  localparam int SP_W    = dfwpm_pkg::SP_W;
  localparam int POS_W   = dfwpm_pkg::POS_W;
  localparam int ID_W    = dfwpm_pkg::ID_W;
  localparam int FR_W    = $bits(dfwpm_pkg::frame_t);

  dfwpm_pkg::eng_state_t state, state_next;

  dfwpm_pkg::op_t     item_op;
  logic [CODE_W-1:0]  item_code;
  logic               item_code_ok;
  logic               item_first;
  logic [ID_W-1:0]    item_pid;

  logic [NODE_AW-1:0] load_node, load_node_next;
  logic [DEPTH_W-1:0] load_depth, load_depth_next;
  logic               load_bad, load_bad_next;
  logic [LINK_W-1:0]  node_count, node_count_next;
  logic [NODE_AW-1:0] walk_node, walk_node_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [CODE_W-1:0]  hist [dfwpm_pkg::HIST_SIZE];
  logic [HAW-1:0]     hist_next;
  logic               hist_we;
  logic [LINK_W-1:0]  cur_node, cur_node_next;
  logic [CODE_W-1:0]  cur_code, cur_code_next;
  logic [HAW-1:0]     cur_tail, cur_tail_next;
  logic [SP_W-1:0]    sp, sp_next;
  logic [LINK_W-1:0]  ret_val, ret_val_next;
  logic [NODE_AW-1:0] tgt, tgt_next;
  logic               done_next;
  dfwpm_pkg::result_t result_next;

  logic               stk_we;
  logic [HAW-1:0]     stk_waddr;
  dfwpm_pkg::frame_t  stk_wdata;
  dfwpm_pkg::frame_t  stk_rdata;
  logic [FR_W-1:0]    stk_rbits;
  logic [HAW-1:0]     stk_raddr;

  logic [DEPTH_W-1:0] eff_w;
  logic [NODE_AW-1:0] ln;
  logic [DEPTH_W-1:0] ld;
  logic               lb;
  logic               last;
  logic               make_node;
  logic [LINK_W-1:0]  link_t;
  logic [DEPTH_W-1:0] len;
  logic [HAW-1:0]     walk_p;
  logic [POS_W-1:0]   p0;

  dfwpm_ram #(.WIDTH(FR_W), .DEPTH(dfwpm_pkg::HIST_SIZE)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rbits)
  );

  assign stk_rdata = dfwpm_pkg::frame_t'(stk_rbits);
  assign stk_raddr = HAW'(sp - SP_W'(1));
  assign busy      = (state != dfwpm_pkg::S_IDLE);

  always_comb begin
    if (pattern_width == '0) begin
      eff_w = DEPTH_W'(1);
    end else if (32'(pattern_width) > 32'(dfwpm_pkg::MAX_WIDTH)) begin
      eff_w = DEPTH_W'(dfwpm_pkg::MAX_WIDTH);
    end else begin
      eff_w = DEPTH_W'(pattern_width);
    end
  end

  assign last = ((load_depth + DEPTH_W'(1)) == eff_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfwpm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_node  <= '0;
      load_depth <= '0;
      load_bad   <= 1'b0;
      node_count <= LINK_W'(1);
      walk_node  <= '0;
      pos        <= '0;
      hist_next  <= '0;
      sp         <= '0;
      done       <= 1'b0;
      for (int i = 0; i < dfwpm_pkg::HIST_SIZE; i++) begin
        hist[i] <= '0;
      end
    end else begin
      load_node  <= load_node_next;
      load_depth <= load_depth_next;
      load_bad   <= load_bad_next;
      node_count <= node_count_next;
      walk_node  <= walk_node_next;
      pos        <= pos_next;
      sp         <= sp_next;
      done       <= done_next;
      if (hist_we) begin
        hist[hist_next] <= item_code;
        hist_next       <= hist_next + HAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_beat) begin
      item_op      <= item.op;
      item_code    <= code;
      item_code_ok <= code_ok;
      item_first   <= item.first;
      item_pid     <= item.pattern_id;
    end
    cur_node <= cur_node_next;
    cur_code <= cur_code_next;
    cur_tail <= cur_tail_next;
    ret_val  <= ret_val_next;
    tgt      <= tgt_next;
    result   <= result_next;
  end

  always_comb begin
    state_next      = state;
    load_node_next  = load_node;
    load_depth_next = load_depth;
    load_bad_next   = load_bad;
    node_count_next = node_count;
    walk_node_next  = walk_node;
    pos_next        = pos;
    sp_next         = sp;
    cur_node_next   = cur_node;
    cur_code_next   = cur_code;
    cur_tail_next   = cur_tail;
    ret_val_next    = ret_val;
    tgt_next        = tgt;
    done_next       = 1'b0;
    result_next     = result;
    hist_we         = 1'b0;
    stk_we          = 1'b0;
    stk_waddr       = sp[HAW-1:0];
    stk_wdata       = '{walk: 1'b0, node: cur_node[NODE_AW-1:0], code: cur_code,
                        tail: cur_tail};
    rd_addr         = cur_node[NODE_AW-1:0];
    wr              = '0;
    wr.child_code   = item_code;
    wr.node         = load_node;
    wr.id           = item_pid;
    wr.depth        = load_depth + DEPTH_W'(1);
    make_node       = 1'b0;
    link_t          = rd.child[item_code];
    len             = rd.depth - DEPTH_W'(1);
    walk_p          = cur_tail - HAW'(len);
    ln              = item_first ? '0 : load_node;
    ld              = item_first ? '0 : load_depth;
    lb              = item_first ? 1'b0 : load_bad;
    p0              = item_first ? '0 : pos;

    unique case (state)
      dfwpm_pkg::S_IDLE: begin
        if (start_beat) begin
          state_next = dfwpm_pkg::S_DISPATCH;
        end
      end

      dfwpm_pkg::S_DISPATCH: begin
        result_next = '0;
        if (item_op == dfwpm_pkg::OP_LOAD) begin
          load_node_next  = ln;
          load_depth_next = ld;
          load_bad_next   = lb;
          if (!lb && (ld < eff_w)) begin
            if (!item_code_ok) begin
              load_bad_next      = 1'b1;
              result_next.status = dfwpm_pkg::STAT_BAD_PAT;
              done_next          = 1'b1;
              state_next         = dfwpm_pkg::S_IDLE;
            end else begin
              rd_addr    = ln;
              state_next = dfwpm_pkg::S_LOAD_LOOK;
            end
          end else begin
            done_next  = 1'b1;
            state_next = dfwpm_pkg::S_IDLE;
          end
        end else begin
          pos_next = (p0 == '1) ? p0 : p0 + POS_W'(1);
          if (!item_code_ok) begin
            walk_node_next = '0;
            done_next      = 1'b1;
            state_next     = dfwpm_pkg::S_IDLE;
          end else begin
            hist_we       = 1'b1;
            cur_node_next = LINK_W'(item_first ? '0 : walk_node);
            cur_code_next = item_code;
            cur_tail_next = hist_next;
            sp_next       = '0;
            state_next    = dfwpm_pkg::S_CALL;
          end
        end
      end

      dfwpm_pkg::S_LOAD_LOOK: begin
        if (link_t < node_count) begin
          rd_addr    = link_t[NODE_AW-1:0];
          tgt_next   = link_t[NODE_AW-1:0];
          state_next = dfwpm_pkg::S_LOAD_TGT;
        end else begin
          make_node = 1'b1;
        end
      end

      dfwpm_pkg::S_LOAD_TGT: begin
        if (rd.depth == (load_depth + DEPTH_W'(1))) begin
          if (last) begin
            if (rd.leaf) begin
              result_next.status   = dfwpm_pkg::STAT_DUP;
              result_next.found_id = rd.id;
            end else begin
              wr.info_we = 1'b1;
              wr.node    = tgt;
              wr.leaf    = 1'b1;
            end
          end
          load_node_next  = tgt;
          load_depth_next = load_depth + DEPTH_W'(1);
          done_next       = 1'b1;
          state_next      = dfwpm_pkg::S_IDLE;
        end else begin
          make_node = 1'b1;
        end
      end

      dfwpm_pkg::S_LOAD_LINK: begin
        wr.child_we     = 1'b1;
        wr.link         = LINK_W'(tgt);
        load_node_next  = tgt;
        load_depth_next = load_depth + DEPTH_W'(1);
        done_next       = 1'b1;
        state_next      = dfwpm_pkg::S_IDLE;
      end

      dfwpm_pkg::S_CALL: begin
        if (cur_node >= node_count) begin
          ret_val_next = '0;
          state_next   = dfwpm_pkg::S_RETURN;
        end else begin
          state_next = dfwpm_pkg::S_CALL_WAIT;
        end
      end

      dfwpm_pkg::S_CALL_WAIT: begin
        if (rd.child[cur_code] != dfwpm_pkg::NUL_LINK) begin
          ret_val_next = rd.child[cur_code];
          state_next   = dfwpm_pkg::S_RETURN;
        end else if (cur_node == '0) begin
          ret_val_next = '0;
          state_next   = dfwpm_pkg::S_RETURN;
        end else begin
          stk_we     = 1'b1;
          sp_next    = sp + SP_W'(1);
          state_next = dfwpm_pkg::S_CALL;
          if (rd.fail != dfwpm_pkg::NUL_LINK) begin
            cur_node_next = rd.fail;
          end else if (len == '0) begin
            wr.fail_we    = 1'b1;
            wr.node       = cur_node[NODE_AW-1:0];
            wr.link       = '0;
            cur_node_next = '0;
          end else begin
            stk_wdata.walk = 1'b1;
            cur_node_next  = '0;
            cur_code_next  = hist[walk_p];
            cur_tail_next  = walk_p;
          end
        end
      end

      dfwpm_pkg::S_RETURN: begin
        if (sp == '0) begin
          walk_node_next = (ret_val >= node_count) ? '0 : ret_val[NODE_AW-1:0];
          state_next     = dfwpm_pkg::S_FIN;
        end else begin
          state_next = dfwpm_pkg::S_POP_WAIT;
        end
      end

      dfwpm_pkg::S_POP_WAIT: begin
        if (!stk_rdata.walk) begin
          wr.child_we   = 1'b1;
          wr.child_code = stk_rdata.code;
          wr.node       = stk_rdata.node;
          wr.link       = ret_val;
          sp_next       = sp - SP_W'(1);
          state_next    = dfwpm_pkg::S_RETURN;
        end else if ((cur_tail + HAW'(1)) == stk_rdata.tail) begin
          wr.fail_we     = 1'b1;
          wr.node        = stk_rdata.node;
          wr.link        = ret_val;
          stk_we         = 1'b1;
          stk_waddr      = stk_raddr;
          stk_wdata      = stk_rdata;
          stk_wdata.walk = 1'b0;
          cur_node_next  = ret_val;
          cur_code_next  = stk_rdata.code;
          cur_tail_next  = stk_rdata.tail;
          state_next     = dfwpm_pkg::S_CALL;
        end else begin
          cur_node_next = ret_val;
          cur_code_next = hist[cur_tail + HAW'(1)];
          cur_tail_next = cur_tail + HAW'(1);
          state_next    = dfwpm_pkg::S_CALL;
        end
      end

      dfwpm_pkg::S_FIN: begin
        rd_addr    = walk_node;
        state_next = dfwpm_pkg::S_FIN_WAIT;
      end

      dfwpm_pkg::S_FIN_WAIT: begin
        if (rd.leaf) begin
          result_next.match        = 1'b1;
          result_next.found_id     = rd.id;
          result_next.end_position = pos;
        end
        done_next  = 1'b1;
        state_next = dfwpm_pkg::S_IDLE;
      end

      default: begin
        state_next = dfwpm_pkg::S_IDLE;
      end
    endcase

    if (make_node) begin
      if (node_count >= LINK_W'(dfwpm_pkg::MAX_NODES)) begin
        load_bad_next      = 1'b1;
        result_next.status = dfwpm_pkg::STAT_FULL;
        done_next          = 1'b1;
        state_next         = dfwpm_pkg::S_IDLE;
      end else begin
        wr.init         = 1'b1;
        wr.node         = node_count[NODE_AW-1:0];
        wr.leaf         = last;
        tgt_next        = node_count[NODE_AW-1:0];
        node_count_next = node_count + LINK_W'(1);
        state_next      = dfwpm_pkg::S_LOAD_LINK;
      end
    end
  end

endmodule

// File: tb/sv/dna_fixed_width_multi_pattern_matcher_top_test.sv
`timescale 1ns / 100ps
// self-checking test of the fixed-width dna multi-pattern matcher top level
// depends on dfwpm_pkg and the design; trie model, driver and monitor live here

module dna_fixed_width_multi_pattern_matcher_top_test;
  import dfwpm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [12:0] NO_LINK = 13'(MAX_NODES);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SYM_W-1:0] cfg_data = '0;

  dna_fixed_width_multi_pattern_matcher_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  item_t pending_items[$];
  result_t predicted_results[$];
  logic [63:0] pattern_lib[$];
  int idle_pct = 0;
  logic hold = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  // trie model state
  logic [7:0] base_byte [4];
  logic [5:0] width_reg;
  logic [12:0] kid [MAX_NODES][4];
  logic [12:0] fail_of [MAX_NODES];
  logic [10:0] id_of [MAX_NODES];
  logic [5:0] depth_of [MAX_NODES];
  logic leaf_of [MAX_NODES];
  logic [12:0] node_count;
  logic [12:0] load_node;
  logic [5:0] load_depth;
  logic load_bad;
  logic [12:0] walk_node;
  logic [1:0] history [128];
  logic [6:0] hist_next;
  logic [31:0] subject_pos;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int letter_code(logic [7:0] b);
    for (int i = 0; i < 4; i++)
      if (b == base_byte[i]) return i;
    return -1;
  endfunction

  function automatic int eff_width(logic [5:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return int'(w);
  endfunction

  function automatic void new_node(logic [12:0] n, logic [5:0] d);
    for (int k = 0; k < 4; k++) kid[n][k] = NO_LINK;
    fail_of[n] = NO_LINK;
    id_of[n] = '0;
    depth_of[n] = d;
    leaf_of[n] = 1'b0;
  endfunction

  function automatic logic [12:0] goto_node(logic [12:0] node, logic [1:0] code,
                                            logic [6:0] tail);
    logic [12:0] l;
    logic [12:0] f;
    logic [5:0] len;
    if (node >= node_count) return '0;
    l = kid[node][code];
    if (l != NO_LINK) return l;
    if (node == 0) return '0;
    f = fail_of[node];
    if (f == NO_LINK) begin
      len = depth_of[node] - 6'd1;
      f = replay_walk(tail - 7'(len), len);
      fail_of[node] = f;
    end
    l = goto_node(f, code, tail);
    kid[node][code] = l;
    return l;
  endfunction

  function automatic logic [12:0] replay_walk(logic [6:0] from, logic [5:0] len);
    logic [12:0] n;
    logic [6:0] p;
    n = '0;
    for (int k = 0; k < len; k++) begin
      p = from + 7'(k);
      n = goto_node(n, history[p], p);
    end
    return n;
  endfunction

  function automatic result_t trie_step(item_t it);
    result_t r;
    int code;
    int w;
    logic [12:0] t;
    logic last;
    r = '0;
    r.status = STAT_OK;
    code = letter_code(it.symbol);
    if (it.op == OP_LOAD) begin
      w = eff_width(width_reg);
      if (it.first) begin
        load_node = '0;
        load_depth = '0;
        load_bad = 1'b0;
      end
      if (!load_bad && load_depth < w && load_node < node_count) begin
        if (code < 0) begin
          load_bad = 1'b1;
          r.status = STAT_BAD_PAT;
        end else begin
          t = kid[load_node][code];
          last = (int'(load_depth) + 1 == w);
          if (t != NO_LINK && t < node_count && depth_of[t] == load_depth + 6'd1) begin
            if (last) begin
              if (leaf_of[t]) begin
                r.status = STAT_DUP;
                r.found_id = id_of[t];
              end else begin
                leaf_of[t] = 1'b1;
                id_of[t] = it.pattern_id;
              end
            end
            load_node = t;
            load_depth++;
          end else if (node_count >= MAX_NODES) begin
            load_bad = 1'b1;
            r.status = STAT_FULL;
          end else begin
            t = node_count;
            node_count++;
            new_node(t, load_depth + 6'd1);
            if (last) begin
              leaf_of[t] = 1'b1;
              id_of[t] = it.pattern_id;
            end
            kid[load_node][code] = t;
            load_node = t;
            load_depth++;
          end
        end
      end
    end else begin
      if (it.first) begin
        walk_node = '0;
        subject_pos = '0;
      end
      if (subject_pos != 32'hFFFF_FFFF) subject_pos++;
      if (code < 0) begin
        walk_node = '0;
      end else begin
        history[hist_next] = 2'(code);
        walk_node = goto_node(walk_node, 2'(code), hist_next);
        hist_next++;
        if (walk_node >= node_count) walk_node = '0;
        if (leaf_of[walk_node]) begin
          r.match = 1'b1;
          r.found_id = id_of[walk_node];
          r.end_position = subject_pos;
        end
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) predicted_results.push_back(trie_step(item));
      if (pending_items.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", result);
      end else begin
        want = predicted_results.pop_front();
        if (result.match !== want.match || result.found_id !== want.found_id ||
            result.end_position !== want.end_position || result.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p actual %p", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PAT_WIDTH) width_reg = val[5:0];
    else base_byte[int'(idx)] = val;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || start || predicted_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void push_item(op_t op, logic [7:0] sym, logic first,
                                    logic [10:0] pid);
    item_t it;
    it.op = op;
    it.symbol = sym;
    it.first = first;
    it.pattern_id = pid;
    pending_items.push_back(it);
  endfunction

  function automatic logic [7:0] foreign_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (letter_code(b) >= 0);
    return b;
  endfunction

  function automatic void load_pattern(logic [63:0] codes, int w, logic [10:0] pid,
                                       int noise);
    logic [7:0] b;
    for (int i = 0; i < w; i++) begin
      b = base_byte[codes[2*i +: 2]];
      if ($urandom_range(99) < noise) b = foreign_byte();
      push_item(OP_LOAD, b, (i == 0) && ($urandom_range(9) != 0), pid);
    end
    if ($urandom_range(9) == 0)
      push_item(OP_LOAD, base_byte[$urandom_range(3)], 1'b0, pid);
  endfunction

  function automatic void fill_phase(int n_pat, int n_subj);
    int w;
    int len;
    logic [63:0] codes;
    logic [63:0] p;
    w = eff_width(width_reg);
    for (int k = 0; k < n_pat; k++) begin
      codes = {$urandom, $urandom};
      if (pattern_lib.size() > 0 && $urandom_range(2) == 0) begin
        p = pattern_lib[$urandom_range(pattern_lib.size() - 1)];
        if ($urandom_range(1) == 0) codes = p;
        else codes[2*(w-1) +: 2] = p[2*(w-1) +: 2] + 2'd1;
      end
      pattern_lib.push_back(codes);
      load_pattern(codes, w, 11'($urandom), 4);
    end
    for (int s = 0; s < n_subj; s++) begin
      len = 0;
      while (len < 24) begin
        if (pattern_lib.size() > 0 && $urandom_range(1) == 0) begin
          p = pattern_lib[$urandom_range(pattern_lib.size() - 1)];
          for (int i = 0; i < w; i++) begin
            push_item(OP_SCAN, base_byte[p[2*i +: 2]], len == 0, 11'($urandom));
            len++;
          end
        end else begin
          push_item(OP_SCAN, ($urandom_range(19) == 0) ? foreign_byte()
                    : base_byte[$urandom_range(3)], len == 0, 11'($urandom));
          len++;
        end
      end
    end
  endfunction

  initial begin
    int widths [10] = '{1, 2, 3, 4, 5, 6, 8, 0, 40, 12};
    logic [63:0] pat;
    base_byte = '{8'd65, 8'd67, 8'd71, 8'd84};
    width_reg = 6'd8;
    for (int n = 0; n < MAX_NODES; n++) new_node(13'(n), '0);
    node_count = 13'd1;
    load_node = '0;
    load_depth = '0;
    load_bad = 1'b0;
    walk_node = '0;
    for (int i = 0; i < 128; i++) history[i] = '0;
    hist_next = '0;
    subject_pos = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: ACGTACGT, its duplicate, a bad letter and symbols after it, scans
    pat = 64'h0000_0000_0000_E4E4;
    load_pattern(pat, 8, 11'd1, 0);
    for (int i = 0; i < 8; i++)
      push_item(OP_LOAD, base_byte[pat[2*i +: 2]], i == 0, 11'd2047);
    push_item(OP_LOAD, 8'd65, 1'b1, 11'd5);
    push_item(OP_LOAD, 8'd0, 1'b0, 11'd5);
    push_item(OP_LOAD, 8'd255, 1'b0, 11'd5);
    push_item(OP_LOAD, 8'd67, 1'b0, 11'd5);
    for (int i = 0; i < 12; i++)
      push_item(OP_SCAN, (i == 10) ? 8'd78 : base_byte[pat[2*(i % 4) +: 2]],
                i == 0, 11'd0);
    pattern_lib.push_back(pat);
    drain();

    write_reg(CFG_BASE_A, 8'd0);
    write_reg(CFG_BASE_C, 8'd255);
    write_reg(CFG_BASE_G, 8'd0);
    write_reg(CFG_BASE_T, 8'd128);
    write_reg(CFG_PAT_WIDTH, 6'd0);
    fill_phase(4, 2);
    drain();
    write_reg(CFG_PAT_WIDTH, 6'd63);
    fill_phase(2, 1);
    drain();
    write_reg(CFG_PAT_WIDTH, 6'd4);
    write_reg(CFG_BASE_G, 8'd71);
    fill_phase(3, 2);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = (ph % 4 == 1) ? 70 : (ph % 4 == 3) ? 17 : 0;
      write_reg(CFG_PAT_WIDTH, 8'(widths[ph]));
      if (ph % 3 == 2) begin
        write_reg(CFG_BASE_A, 8'($urandom));
        write_reg(CFG_BASE_C, 8'($urandom));
        write_reg(CFG_BASE_G, 8'($urandom));
        write_reg(CFG_BASE_T, ($urandom_range(4) == 0) ? base_byte[0] : 8'($urandom));
      end
      fill_phase(4, 2);
      if (ph == 4) begin
        while (pending_items.size() > 40) @(posedge clk);
        hold <= 1'b1;
        while (start || predicted_results.size() > 0) @(posedge clk);
        hold <= 1'b0;
      end
      drain();
    end

    // long patterns at full width
    idle_pct = 0;
    write_reg(CFG_PAT_WIDTH, 8'd32);
    for (int k = 0; k < 2; k++) load_pattern({$urandom, $urandom}, 32, 11'($urandom), 1);
    fill_phase(1, 1);
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
